// File: rtl/core/ipv4_port_line_validator_core_assert.svh
// ----------------------------------------------------------------------------
// ipv4_port_line_validator_core_assert.svh
// assertion macros shared by the checker, sampled on clk, idle under rst_n
// ----------------------------------------------------------------------------
`ifndef IPV4_PORT_LINE_VALIDATOR_CORE_ASSERT_SVH
`define IPV4_PORT_LINE_VALIDATOR_CORE_ASSERT_SVH

// one sequence property, quiet while in reset
`define IPVPL_ASSERT_SEQ(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication, quiet while in reset
`define IPVPL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ipvpl_pkg.sv
// ----------------------------------------------------------------------------
// ipvpl_pkg
// shared types and constants of the address and port line validator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipvpl_pkg;

  localparam logic [7:0]  SPACE_CH    = 8'h20;
  localparam logic [7:0]  DOT_CH      = 8'h2E;
  localparam logic [7:0]  DIGIT_LO    = 8'h30;
  localparam logic [7:0]  DIGIT_HI    = 8'h39;
  localparam logic [11:0] OCTET_MAX   = 12'd255;
  localparam logic [19:0] PORT_MAX    = 20'd65535;
  localparam logic [16:0] PORT_SAT    = 17'd65536;
  localparam logic [2:0]  OCTETS_ALL  = 3'd4;
  localparam logic [2:0]  OCTETS_LAST = 3'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic  step;
    beat_t beat;
  } s1_t;

  typedef struct packed {
    logic        valid_res;
    logic [31:0] address;
    logic [15:0] port_number;
  } res_t;

  typedef struct packed {
    logic load;
    res_t res;
  } res_beat_t;

endpackage

`default_nettype wire

// File: rtl/core/ipvpl_in_stage.sv
// ----------------------------------------------------------------------------
// ipvpl_in_stage
// input register: holds one byte beat until the parser can consume it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipvpl_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_ch,
  input  wire logic          in_last,
  input  wire logic          out_free,
  output ipvpl_pkg::s1_t     s1
);
  import ipvpl_pkg::*;

  logic  vld_r, vld_nxt;
  beat_t beat_r, beat_nxt;
  logic  step;

  // a non-final byte never needs the result slot
  assign step     = vld_r && (!beat_r.last || out_free);
  assign in_ready = !vld_r || step;

  always_comb begin
    vld_nxt  = vld_r;
    beat_nxt = beat_r;
    if (in_ready) begin
      vld_nxt = in_valid;
      if (in_valid) begin
        beat_nxt.ch   = in_ch;
        beat_nxt.last = in_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign s1.step = step;
  assign s1.beat = beat_r;

endmodule

`default_nettype wire

// File: rtl/core/ipvpl_parser.sv
// ----------------------------------------------------------------------------
// ipvpl_parser
// line state and the per-byte update; produces the verdict on the final byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipvpl_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ipvpl_pkg::s1_t  s1,
  output ipvpl_pkg::res_beat_t rb
);
  import ipvpl_pkg::*;

  typedef enum logic [5:0] {
    PH_LEAD = 6'b000001,
    PH_ADDR = 6'b000010,
    PH_GAP  = 6'b000100,
    PH_PORT = 6'b001000,
    PH_TAIL = 6'b010000,
    PH_ERR  = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  octets_r, octets_nxt;
  logic [7:0]  oct_r, oct_nxt;
  logic [1:0]  digits_r, digits_nxt;
  logic        lz_r, lz_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [16:0] port_r, port_nxt;

  logic        is_digit;
  logic        is_space;
  logic        is_dot;
  logic [3:0]  dgt;
  logic [11:0] oct_x10;
  logic [19:0] port_x10;
  logic        do_ad;
  logic        do_pd;
  logic        ok;

  always_comb begin
    is_digit = (s1.beat.ch inside {[DIGIT_LO:DIGIT_HI]});
    is_space = (s1.beat.ch == SPACE_CH);
    is_dot   = (s1.beat.ch == DOT_CH);
    dgt      = is_digit ? s1.beat.ch[3:0] : 4'd0;
    oct_x10  = ({4'd0, oct_r} << 3) + ({4'd0, oct_r} << 1) + {8'd0, dgt};
    port_x10 = ({3'd0, port_r} << 3) + ({3'd0, port_r} << 1) + {16'd0, dgt};

    phase_nxt  = phase_r;
    octets_nxt = octets_r;
    oct_nxt    = oct_r;
    digits_nxt = digits_r;
    lz_nxt     = lz_r;
    addr_nxt   = addr_r;
    port_nxt   = port_r;
    do_ad      = 1'b0;
    do_pd      = 1'b0;

    case (phase_r)
      PH_LEAD: begin
        if (is_space) begin
        end else if (is_digit) begin
          phase_nxt = PH_ADDR;
          do_ad     = 1'b1;
        end else begin
          phase_nxt = PH_ERR;
        end
      end
      PH_ADDR: begin
        if (is_digit) begin
          do_ad = 1'b1;
        end else if (is_dot) begin
          if (digits_r == 2'd0) begin
            phase_nxt = PH_ERR;
          end else begin
            addr_nxt   = {addr_r[23:0], oct_r};
            octets_nxt = octets_r + 3'd1;
            oct_nxt    = 8'd0;
            digits_nxt = 2'd0;
            lz_nxt     = 1'b0;
          end
        end else if (is_space) begin
          if (digits_r == 2'd0) begin
            phase_nxt = (octets_r == OCTETS_ALL) ? PH_GAP : PH_ERR;
          end else if (octets_r != OCTETS_LAST) begin
            phase_nxt = PH_ERR;
          end else begin
            addr_nxt   = {addr_r[23:0], oct_r};
            octets_nxt = OCTETS_ALL;
            oct_nxt    = 8'd0;
            digits_nxt = 2'd0;
            lz_nxt     = 1'b0;
            phase_nxt  = PH_GAP;
          end
        end else begin
          phase_nxt = PH_ERR;
        end
      end
      PH_GAP: begin
        if (is_space) begin
        end else if (is_digit) begin
          phase_nxt = PH_PORT;
          do_pd     = 1'b1;
        end else begin
          phase_nxt = PH_ERR;
        end
      end
      PH_PORT: begin
        if (is_digit) begin
          do_pd = 1'b1;
        end else if (is_space) begin
          phase_nxt = PH_TAIL;
        end else begin
          phase_nxt = PH_ERR;
        end
      end
      PH_TAIL: begin
        if (!is_space) begin
          phase_nxt = PH_ERR;
        end
      end
      default: begin
        phase_nxt = PH_ERR;
      end
    endcase

    // octet digit: no fifth octet, no digit after a leading zero, no overflow
    if (do_ad) begin
      if (octets_r >= OCTETS_ALL || lz_r || oct_x10 > OCTET_MAX) begin
        phase_nxt = PH_ERR;
      end else begin
        if (digits_r == 2'd0 && dgt == 4'd0) begin
          lz_nxt = 1'b1;
        end
        oct_nxt    = oct_x10[7:0];
        digits_nxt = digits_r + 2'd1;
      end
    end

    // port digit saturates one above the largest port
    if (do_pd) begin
      port_nxt = (port_x10 > PORT_MAX) ? PORT_SAT : port_x10[16:0];
    end

    ok = (phase_nxt == PH_PORT || phase_nxt == PH_TAIL) && !port_nxt[16];
    rb.load            = s1.step && s1.beat.last;
    rb.res.valid_res   = ok;
    rb.res.address     = ok ? addr_nxt : 32'd0;
    rb.res.port_number = ok ? port_nxt[15:0] : 16'd0;

    // back to the start after the final byte
    if (s1.beat.last) begin
      phase_nxt  = PH_LEAD;
      octets_nxt = 3'd0;
      oct_nxt    = 8'd0;
      digits_nxt = 2'd0;
      lz_nxt     = 1'b0;
      addr_nxt   = 32'd0;
      port_nxt   = 17'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEAD;
      octets_r <= 3'd0;
      oct_r    <= 8'd0;
      digits_r <= 2'd0;
      lz_r     <= 1'b0;
      addr_r   <= 32'd0;
      port_r   <= 17'd0;
    end else if (s1.step) begin
      phase_r  <= phase_nxt;
      octets_r <= octets_nxt;
      oct_r    <= oct_nxt;
      digits_r <= digits_nxt;
      lz_r     <= lz_nxt;
      addr_r   <= addr_nxt;
      port_r   <= port_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ipvpl_out_stage.sv
// ----------------------------------------------------------------------------
// ipvpl_out_stage
// result register: holds one verdict beat until the consumer takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipvpl_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ipvpl_pkg::res_beat_t rb,
  output logic                      out_free,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_valid_res,
  output logic [31:0]               out_address,
  output logic [15:0]               out_port_number
);
  import ipvpl_pkg::*;

  logic vld_r, vld_nxt;
  res_t res_r, res_nxt;

  assign out_free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    res_nxt = res_r;
    if (rb.load) begin
      vld_nxt = 1'b1;
      res_nxt = rb.res;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid       = vld_r;
  assign out_valid_res   = res_r.valid_res;
  assign out_address     = res_r.address;
  assign out_port_number = res_r.port_number;

endmodule

`default_nettype wire

// File: rtl/core/ipv4_port_line_validator_core.sv
// ----------------------------------------------------------------------------
// ipv4_port_line_validator_core
// checks that a byte-serial line reads "address spaces port", with leading and
// trailing spaces allowed, and reports the parsed address and port on the final byte
// ----------------------------------------------------------------------------
// verdict path: the final byte's beat is held in the input register, then its
//   verdict is loaded into the result register
// throughput: one byte per cycle; a final byte waits only while the result
//   register still holds an untaken verdict
// reset: synchronous rst_n clears both stages and returns the parser to the
//   leading-space phase with all accumulators at zero
`timescale 1ns / 1ps
`default_nettype none

module ipv4_port_line_validator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_valid_res,
  output logic [31:0]      out_address,
  output logic [15:0]      out_port_number
);
  import ipvpl_pkg::*;

  s1_t       s1;
  res_beat_t rb;
  logic      out_free;

  ipvpl_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .in_last  (in_last),
    .out_free (out_free),
    .s1       (s1)
  );

  ipvpl_parser u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .s1    (s1),
    .rb    (rb)
  );

  ipvpl_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .rb              (rb),
    .out_free        (out_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_valid_res   (out_valid_res),
    .out_address     (out_address),
    .out_port_number (out_port_number)
  );

endmodule

`default_nettype wire

// File: rtl/core/ipvpl_checker.sv
// ----------------------------------------------------------------------------
// ipvpl_checker
// port-level checks on the validator core, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ipv4_port_line_validator_core_assert.svh"

module ipvpl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_last,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_valid_res,
  input wire logic [31:0] out_address,
  input wire logic [15:0] out_port_number
);

  // stalled result beat keeps its payload
  `IPVPL_ASSERT_SEQ(a_out_hold,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_valid_res) &&
      $stable(out_address) && $stable(out_port_number)),
    "result beat changed while stalled")

  // a failing line reports zero address and port
  `IPVPL_ASSERT_IMPL(a_bad_zero, out_valid && !out_valid_res,
    out_address == 32'd0 && out_port_number == 16'd0,
    "invalid line with nonzero fields")

  // a final byte waiting behind a stalled result blocks the input
  `IPVPL_ASSERT_SEQ(a_last_block,
    (in_valid && in_ready && in_last) ##1 (out_valid && !out_ready) |-> !in_ready,
    "input taken while final byte is stuck")

endmodule

bind ipv4_port_line_validator_core ipvpl_checker u_chk (.*);

`default_nettype wire

// File: dv/ipv4_port_line_validator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_port_line_validator_core_test
// feeds byte-serial lines through the validator and compares every verdict
// with a line parser kept in the bench; directed lines cover the edge cases,
// then mostly well-formed random lines with some mangled ones and pure noise,
// with random gaps on the byte side and random back-pressure on the verdicts
// ----------------------------------------------------------------------------

module ipv4_port_line_validator_core_test;
  import ipvpl_pkg::*;

  localparam int RANDOM_BYTES = 1640;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  typedef enum logic [2:0] {
    SCAN_LEAD, SCAN_ADDR, SCAN_GAP, SCAN_PORT, SCAN_TAIL, SCAN_BAD
  } scan_t;

  class line_verdict_board;
    res_t        verdict_q[$];
    scan_t       phase;
    logic [2:0]  octets;
    logic [8:0]  oct_val;
    logic [1:0]  oct_digits;
    bit          oct_lead_zero;
    logic [31:0] addr_acc;
    logic [16:0] port_acc;
    int          mismatches;
    int          verdicts_seen;
    int          verdicts_good;

    function new();
      clear_line();
    endfunction

    function void clear_octet();
      oct_val       = '0;
      oct_digits    = '0;
      oct_lead_zero = 1'b0;
    endfunction

    function void clear_line();
      phase    = SCAN_LEAD;
      octets   = '0;
      addr_acc = '0;
      port_acc = '0;
      clear_octet();
    endfunction

    function void addr_digit(int d);
      int v;
      if (octets >= OCTETS_ALL || oct_lead_zero) begin
        phase = SCAN_BAD;
        return;
      end
      v = oct_val * 10 + d;
      if (v > OCTET_MAX) begin
        phase = SCAN_BAD;
        return;
      end
      if (oct_digits == 0 && d == 0) oct_lead_zero = 1'b1;
      oct_val    = 9'(v);
      oct_digits = oct_digits + 2'd1;
    endfunction

    function void port_digit(int d);
      int v;
      v = port_acc * 10 + d;
      port_acc = (v > PORT_MAX) ? PORT_SAT : 17'(v);
    endfunction

    // one accepted input beat; a final byte queues the verdict for the line
    function void take_byte(logic [7:0] ch, logic last);
      bit   dig;
      bit   spc;
      int   d;
      bit   ok;
      res_t r;
      dig = (ch >= DIGIT_LO) && (ch <= DIGIT_HI);
      spc = (ch == SPACE_CH);
      d   = dig ? int'(ch - DIGIT_LO) : 0;
      case (phase)
        SCAN_LEAD: begin
          if (dig) begin
            phase = SCAN_ADDR;
            addr_digit(d);
          end else if (!spc) begin
            phase = SCAN_BAD;
          end
        end
        SCAN_ADDR: begin
          if (dig) begin
            addr_digit(d);
          end else if (ch == DOT_CH) begin
            if (oct_digits == 0) begin
              phase = SCAN_BAD;
            end else begin
              addr_acc = {addr_acc[23:0], oct_val[7:0]};
              octets   = octets + 3'd1;
              clear_octet();
            end
          end else if (spc) begin
            if (oct_digits == 0) begin
              phase = (octets == OCTETS_ALL) ? SCAN_GAP : SCAN_BAD;
            end else if (octets != OCTETS_LAST) begin
              phase = SCAN_BAD;
            end else begin
              addr_acc = {addr_acc[23:0], oct_val[7:0]};
              octets   = OCTETS_ALL;
              clear_octet();
              phase    = SCAN_GAP;
            end
          end else begin
            phase = SCAN_BAD;
          end
        end
        SCAN_GAP: begin
          if (dig) begin
            phase = SCAN_PORT;
            port_digit(d);
          end else if (!spc) begin
            phase = SCAN_BAD;
          end
        end
        SCAN_PORT: begin
          if (dig) port_digit(d);
          else if (spc) phase = SCAN_TAIL;
          else phase = SCAN_BAD;
        end
        SCAN_TAIL: begin
          if (!spc) phase = SCAN_BAD;
        end
        default: phase = SCAN_BAD;
      endcase
      if (!last) return;
      ok = (phase == SCAN_PORT || phase == SCAN_TAIL) && (port_acc <= PORT_MAX);
      r.valid_res   = ok;
      r.address     = ok ? addr_acc : '0;
      r.port_number = ok ? port_acc[15:0] : '0;
      verdict_q.push_back(r);
      clear_line();
    endfunction

    function void check_verdict(logic vr, logic [31:0] addr, logic [15:0] port);
      res_t exp_r;
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] verdict with none pending: valid=%0b addr=%h port=%0d",
                   $realtime, vr, addr, port);
        return;
      end
      exp_r = verdict_q.pop_front();
      if (exp_r.valid_res) verdicts_good++;
      if (vr !== exp_r.valid_res || addr !== exp_r.address ||
          port !== exp_r.port_number) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] verdict mismatch: exp valid=%0b addr=%h port=%0d, %s",
                   $realtime, exp_r.valid_res, exp_r.address, exp_r.port_number,
                   $sformatf("got valid=%0b addr=%h port=%0d", vr, addr, port));
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_ch = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_valid_res;
  logic [31:0] out_address;
  logic [15:0] out_port_number;

  line_verdict_board board = new();
  logic [7:0]        line_buf[$];
  bit                calm;
  int                sent_bytes;
  int                sent_lines;
  int                cycles;

  ipv4_port_line_validator_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_valid_res   (out_valid_res),
    .out_address     (out_address),
    .out_port_number (out_port_number)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // input beat first, so a verdict is always queued before it can be seen
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.take_byte(in_ch, in_last);
    if (rst_n && out_valid && out_ready)
      board.check_verdict(out_valid_res, out_address, out_port_number);
  end

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  task automatic send_line();
    int gap;
    for (int i = 0; i < line_buf.size(); i++) begin
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_ch    <= line_buf[i];
      in_last  <= (i == line_buf.size() - 1);
      do @(posedge clk); while (!in_ready);
      sent_bytes++;
    end
    sent_lines++;
    line_buf.delete();
  endtask

  task automatic send_text(string s);
    put_text(s);
    send_line();
  endtask

  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic string octet_text();
    case ($urandom_range(0, 9))
      0:       return "0";
      1, 2, 3: return $sformatf("%0d", $urandom_range(1, 9));
      4, 5:    return $sformatf("%0d", $urandom_range(10, 99));
      6, 7, 8: return $sformatf("%0d", $urandom_range(100, 255));
      default: begin
        if ($urandom_range(0, 1)) return $sformatf("%0d", $urandom_range(256, 999));
        return $sformatf("0%0d", $urandom_range(0, 99));
      end
    endcase
  endfunction

  function automatic string port_text();
    string s;
    case ($urandom_range(0, 9))
      0, 1:    return $sformatf("%0d", $urandom_range(0, 9));
      2, 3, 4: return $sformatf("%0d", $urandom_range(10, 65535));
      5:       return $sformatf("%0d", $urandom_range(65530, 65535));
      6:       return $sformatf("00%0d", $urandom_range(0, 65535));
      7:       return $sformatf("%0d", $urandom_range(65536, 99999));
      default: begin
        s = "";
        repeat ($urandom_range(1, 8)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        return s;
      end
    endcase
  endfunction

  // mostly well-formed lines, some with one byte mangled, some pure noise
  task automatic build_random_line();
    int    kind;
    int    pos;
    string picks;
    picks = "0.9 ";
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) put_text(" ");
    for (int k = 0; k < 4; k++) begin
      if (k != 0) put_text(".");
      put_text(octet_text());
    end
    if ($urandom_range(0, 5) == 0) put_text(".");
    repeat ($urandom_range(1, 3)) put_text(" ");
    put_text(port_text());
    repeat ($urandom_range(0, 2)) put_text(" ");
    if (kind <= 3) begin
      pos = $urandom_range(0, line_buf.size() - 1);
      case ($urandom_range(0, 3))
        0: line_buf[pos] = 8'($urandom_range(0, 255));
        1: line_buf[pos] = picks[$urandom_range(0, 3)];
        2: if (line_buf.size() > 1) line_buf.delete(pos);
        default: line_buf.insert(pos, picks[$urandom_range(0, 3)]);
      endcase
    end
  endtask

  initial begin
    int random_start;
    calm = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed lines
    send_text("0.0.0.0 0");
    send_text("255.255.255.255 65535");
    send_text("  10.20.30.40   8080  ");
    send_text("1.2.3.4. 80");
    send_text("1.2.3.4.5 80");
    send_text("1.2.3.4.. 80");
    send_text("1.2.3. 80");
    send_text("1..2.3 4");
    send_text(".1.2.3.4 5");
    send_text("1.2.3.4 . 5");
    send_text("01.2.3.4 5");
    send_text("256.1.1.1 5");
    send_text("1.2.3.4 65536");
    send_text("9.8.7.6 0000065535");
    send_text("1.2.3.4 9999999");
    send_text("1.2.3.4\t5");
    send_text("1.2.3.4 5a");
    send_text("   ");
    send_text("1.2.3.4 ");
    send_text("1.2.3.4");
    line_buf.push_back(8'hFF);
    send_line();
    line_buf.push_back(8'h00);
    send_line();
    put_text("1.2.3.4 ");
    line_buf.push_back(8'h80);
    send_line();

    random_start = sent_bytes;
    while (sent_bytes - random_start < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 9) == 0);
      build_random_line();
      send_line();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("lines sent: %0d (%0d bytes), verdicts checked: %0d, valid lines: %0d",
             sent_lines, sent_bytes, board.verdicts_seen, board.verdicts_good);
    $display("mismatches: %0d, verdicts still pending: %0d",
             board.mismatches, board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
